@@ hw/rtl/msc_pkg.sv @@
package msc_pkg;

  localparam int MAX_SECTIONS = 24;
  localparam int SEC_W        = 5;
  localparam int PT_DEPTH     = MAX_SECTIONS * 2;
  localparam int PT_AW        = $clog2(PT_DEPTH);
  localparam int WORD_W       = 96;
  localparam int DAMP_W       = 17;
  localparam logic [DAMP_W-1:0] ONE_Q16 = DAMP_W'(65536);

  // item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_TENSION  = 2'd0;
  localparam logic [1:0] REG_DAMPING  = 2'd1;
  localparam logic [1:0] REG_GRAVITY  = 2'd2;
  localparam logic [1:0] REG_SECTIONS = 2'd3;

  // component codes
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PRE,
    OP_PCAP,
    OP_RD,
    OP_CAP,
    OP_DMP,
    OP_SQ,
    OP_BT,
    OP_AT,
    OP_ACC,
    OP_WB,
    OP_PWR,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SEC_W-1:0] sec;
    logic             side;
    logic [1:0]       comp;
    logic             second;
    logic             last;
  } cmd_t;

  function automatic logic [PT_AW-1:0] pt_addr(input logic [SEC_W-1:0] sec, input logic side);
    pt_addr = PT_AW'({sec, side});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  function automatic logic signed [31:0] comp_sel(input logic [WORD_W-1:0] w,
                                                  input logic [1:0] c);
    case (c)
      COMP_X:  comp_sel = w[31:0];
      COMP_Y:  comp_sel = w[63:32];
      COMP_Z:  comp_sel = w[95:64];
      default: comp_sel = w[31:0];
    endcase
  endfunction

endpackage

@@ hw/rtl/mass_spring_chain_step.sv @@
// a load transfer is written in the cycle it is accepted, and the block stays ready for the next item
// a tick pre-reads the section-zero points, then for each interior point, side zero then side one:
// one memory read, then per component a capture, a damping step and two spring passes on the
// single shared multiplier and a component write back, then one position write back and one
// emit, which waits while the result side stalls
// reset (synchronous, rst_n low): registers to defaults, all velocities read as zero
module mass_spring_chain_step (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [4:0]         in_section,
  input  logic               in_side,
  input  logic signed [31:0] in_load_x,
  input  logic signed [31:0] in_load_y,
  input  logic signed [31:0] in_load_z,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_section,
  output logic               out_side,
  output logic signed [31:0] out_new_x,
  output logic signed [31:0] out_new_y,
  output logic signed [31:0] out_new_z,
  output logic               out_last_point,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [31:0]               tension_r;
  logic [msc_pkg::DAMP_W-1:0]       damping_r;
  logic signed [31:0]               gravity_r;
  logic [msc_pkg::SEC_W-1:0]        sections_r;
  logic [msc_pkg::DAMP_W-1:0]       damp_eff;
  logic                             cfg_wr;
  logic [1:0]                       cfg_idx;
  msc_pkg::cmd_t                    cmd;

  // register write on the access phase of a transfer
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tension_r  <= '0;
      damping_r  <= '0;
      gravity_r  <= '0;
      sections_r <= msc_pkg::SEC_W'(msc_pkg::MAX_SECTIONS);
    end else if (cfg_wr) begin
      case (cfg_idx)
        msc_pkg::REG_TENSION:  tension_r  <= pwdata;
        msc_pkg::REG_DAMPING:  damping_r  <= pwdata[msc_pkg::DAMP_W-1:0];
        msc_pkg::REG_GRAVITY:  gravity_r  <= pwdata;
        msc_pkg::REG_SECTIONS: sections_r <= pwdata[msc_pkg::SEC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (cfg_idx)
      msc_pkg::REG_TENSION:  prdata = tension_r;
      msc_pkg::REG_DAMPING:  prdata = 32'(damping_r);
      msc_pkg::REG_GRAVITY:  prdata = gravity_r;
      msc_pkg::REG_SECTIONS: prdata = 32'(sections_r);
      default:               prdata = '0;
    endcase
  end

  // damping above one saturates at one
  assign damp_eff = (damping_r > msc_pkg::ONE_Q16) ? msc_pkg::ONE_Q16 : damping_r;

  // sequencer: walks interior points, issues one datapath step per cycle unless the result side stalls
  msc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_section    (in_section),
    .in_side       (in_side),
    .section_count (sections_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cmd           (cmd)
  );

  // point memories, shared multiplier and result register
  msc_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .load_x         (in_load_x),
    .load_y         (in_load_y),
    .load_z         (in_load_z),
    .tension        (tension_r),
    .damp           (damp_eff),
    .gravity        (gravity_r),
    .out_section    (out_section),
    .out_side       (out_side),
    .out_new_x      (out_new_x),
    .out_new_y      (out_new_y),
    .out_new_z      (out_new_z),
    .out_last_point (out_last_point)
  );

`ifndef SYNTHESIS
  // a pending result that is not the last one means a tick is still running
  a_busy_on_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_point) |-> !in_ready)
    else $error("input accepted while a tick is in progress");

  // a tick with interior sections holds off the input channel
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == msc_pkg::CMD_TICK) && (sections_r > 5'd2))
    |=> !in_ready)
    else $error("tick did not start");

  // the final point of a tick is always on side one
  a_last_side: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_point) |-> out_side)
    else $error("last point flagged on side zero");
`endif

endmodule

@@ hw/rtl/msc_ctrl.sv @@
module msc_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_command,
  input  logic [msc_pkg::SEC_W-1:0] in_section,
  input  logic                    in_side,
  input  logic [msc_pkg::SEC_W-1:0] section_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output msc_pkg::cmd_t           cmd
);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_PRE  = 13'b0000000000010,
    ST_PCAP = 13'b0000000000100,
    ST_RD   = 13'b0000000001000,
    ST_CAP  = 13'b0000000010000,
    ST_DMP  = 13'b0000000100000,
    ST_SQ   = 13'b0000001000000,
    ST_BT   = 13'b0000010000000,
    ST_AT   = 13'b0000100000000,
    ST_ACC  = 13'b0001000000000,
    ST_WB   = 13'b0010000000000,
    ST_PWR  = 13'b0100000000000,
    ST_EMIT = 13'b1000000000000
  } state_t;

  localparam logic [msc_pkg::SEC_W-1:0] SEC_MAX = msc_pkg::SEC_W'(msc_pkg::MAX_SECTIONS);
  localparam logic [msc_pkg::SEC_W-1:0] SEC_TWO = msc_pkg::SEC_W'(2);
  localparam logic [msc_pkg::SEC_W-1:0] SEC_ONE = msc_pkg::SEC_W'(1);

  state_t                      state_r, state_nxt;
  logic [msc_pkg::SEC_W-1:0]   s_r, s_nxt;
  logic [msc_pkg::SEC_W-1:0]   n_r, n_nxt;
  logic                        sd_r, sd_nxt;
  logic [1:0]                  c_r, c_nxt;
  logic                        second_r, second_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [msc_pkg::SEC_W-1:0]   n_clamp;
  logic                        last;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign last      = (s_r == n_r - SEC_TWO) && sd_r;

  always_comb begin
    if (section_count < SEC_TWO) begin
      n_clamp = SEC_TWO;
    end else if (section_count > SEC_MAX) begin
      n_clamp = SEC_MAX;
    end else begin
      n_clamp = section_count;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    s_nxt         = s_r;
    n_nxt         = n_r;
    sd_nxt        = sd_r;
    c_nxt         = c_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = msc_pkg::OP_NONE;
    cmd.sec       = s_r;
    cmd.side      = sd_r;
    cmd.comp      = c_r;
    cmd.second    = second_r;
    cmd.last      = last;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_command == msc_pkg::CMD_LOAD) begin
            if (in_section < SEC_MAX) begin
              cmd.op   = msc_pkg::OP_LOAD;
              cmd.sec  = in_section;
              cmd.side = in_side;
            end
          end else begin
            n_nxt = n_clamp;
            if (n_clamp > SEC_TWO) begin
              s_nxt     = SEC_ONE;
              sd_nxt    = 1'b0;
              state_nxt = ST_PRE;
            end
          end
        end
      end
      ST_PRE: begin
        cmd.op    = msc_pkg::OP_PRE;
        state_nxt = ST_PCAP;
      end
      ST_PCAP: begin
        cmd.op    = msc_pkg::OP_PCAP;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.op     = msc_pkg::OP_RD;
        c_nxt      = msc_pkg::COMP_X;
        second_nxt = 1'b0;
        state_nxt  = ST_CAP;
      end
      ST_CAP: begin
        cmd.op    = msc_pkg::OP_CAP;
        state_nxt = ST_DMP;
      end
      ST_DMP: begin
        cmd.op    = msc_pkg::OP_DMP;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.op    = msc_pkg::OP_SQ;
        state_nxt = ST_BT;
      end
      ST_BT: begin
        cmd.op    = msc_pkg::OP_BT;
        state_nxt = ST_AT;
      end
      ST_AT: begin
        cmd.op    = msc_pkg::OP_AT;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op = msc_pkg::OP_ACC;
        if (!second_r) begin
          second_nxt = 1'b1;
          state_nxt  = ST_SQ;
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        cmd.op     = msc_pkg::OP_WB;
        second_nxt = 1'b0;
        if (c_r == msc_pkg::COMP_Z) begin
          state_nxt = ST_PWR;
        end else begin
          c_nxt     = c_r + 2'd1;
          state_nxt = ST_CAP;
        end
      end
      ST_PWR: begin
        cmd.op    = msc_pkg::OP_PWR;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = msc_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          if (last) begin
            state_nxt = ST_IDLE;
          end else if (!sd_r) begin
            sd_nxt    = 1'b1;
            state_nxt = ST_RD;
          end else begin
            sd_nxt    = 1'b0;
            s_nxt     = s_r + SEC_ONE;
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s_r         <= SEC_ONE;
      n_r         <= SEC_MAX;
      sd_r        <= 1'b0;
      c_r         <= msc_pkg::COMP_X;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s_r         <= s_nxt;
      n_r         <= n_nxt;
      sd_r        <= sd_nxt;
      c_r         <= c_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/msc_dpath.sv @@
module msc_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  msc_pkg::cmd_t               cmd,
  input  logic signed [31:0]          load_x,
  input  logic signed [31:0]          load_y,
  input  logic signed [31:0]          load_z,
  input  logic signed [31:0]          tension,
  input  logic [msc_pkg::DAMP_W-1:0]  damp,
  input  logic signed [31:0]          gravity,
  output logic [msc_pkg::SEC_W-1:0]   out_section,
  output logic                        out_side,
  output logic signed [31:0]          out_new_x,
  output logic signed [31:0]          out_new_y,
  output logic signed [31:0]          out_new_z,
  output logic                        out_last_point
);

  logic [msc_pkg::WORD_W-1:0] pos_mem [msc_pkg::PT_DEPTH];
  logic [msc_pkg::WORD_W-1:0] vel_mem [msc_pkg::PT_DEPTH];
  logic [msc_pkg::PT_DEPTH-1:0] vel_ok_r;

  logic [msc_pkg::WORD_W-1:0] qa_r, qb_r, vq_r;
  logic                       vq_ok_r;
  logic [msc_pkg::WORD_W-1:0] prev_r [2];
  logic [msc_pkg::WORD_W-1:0] np_r, nv_r;

  logic signed [65:0] prod_r;
  logic signed [31:0] d_r, dp_r, vc_r, acc_r, sq_r, b_r, f_r;

  logic [msc_pkg::SEC_W-1:0]  sec_r;
  logic                       side_r, last_r;
  logic signed [31:0]         nx_r, ny_r, nz_r;

  logic                       rd_en;
  logic [msc_pkg::PT_AW-1:0]  ra, rb, pt;
  logic                       pos_we;
  logic [msc_pkg::WORD_W-1:0] pos_wd;
  logic signed [32:0]         mul_a, mul_b;
  logic signed [32:0]         d_abs;
  logic signed [31:0]         vc, own, nxt, prv, gadd;

  assign pt = msc_pkg::pt_addr(cmd.sec, cmd.side);

  always_comb begin
    rd_en = 1'b0;
    ra    = pt;
    rb    = msc_pkg::pt_addr(cmd.sec + msc_pkg::SEC_W'(1), cmd.side);
    if (cmd.op == msc_pkg::OP_PRE) begin
      rd_en = 1'b1;
      ra    = msc_pkg::pt_addr('0, 1'b0);
      rb    = msc_pkg::pt_addr('0, 1'b1);
    end else if (cmd.op == msc_pkg::OP_RD) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    pos_we = 1'b0;
    pos_wd = np_r;
    if (cmd.op == msc_pkg::OP_LOAD) begin
      pos_we = 1'b1;
      pos_wd = {load_z, load_y, load_x};
    end else if (cmd.op == msc_pkg::OP_PWR) begin
      pos_we = 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pt] <= pos_wd;
    end
    if (rd_en) begin
      qa_r <= pos_mem[ra];
      qb_r <= pos_mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == msc_pkg::OP_PWR) begin
      vel_mem[pt] <= nv_r;
    end
    if (rd_en) begin
      vq_r    <= vel_mem[ra];
      vq_ok_r <= vel_ok_r[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_ok_r <= '0;
    end else if (cmd.op == msc_pkg::OP_LOAD) begin
      vel_ok_r[pt] <= 1'b0;
    end else if (cmd.op == msc_pkg::OP_PWR) begin
      vel_ok_r[pt] <= 1'b1;
    end
  end

  // component operands
  always_comb begin
    vc    = vq_ok_r ? msc_pkg::comp_sel(vq_r, cmd.comp) : 32'sd0;
    own   = msc_pkg::comp_sel(qa_r, cmd.comp);
    nxt   = msc_pkg::comp_sel(qb_r, cmd.comp);
    prv   = msc_pkg::comp_sel(prev_r[cmd.side], cmd.comp);
    gadd  = (cmd.comp == msc_pkg::COMP_Y) ? gravity : 32'sd0;
    d_abs = d_r[31] ? -33'(d_r) : 33'(d_r);
  end

  always_comb begin
    mul_a = 33'(vc);
    mul_b = $signed({16'd0, damp});
    case (cmd.op)
      msc_pkg::OP_DMP, msc_pkg::OP_ACC: begin
        mul_a = d_abs;
        mul_b = 33'(d_r);
      end
      msc_pkg::OP_SQ: begin
        mul_a = 33'(d_r);
        mul_b = 33'(tension);
      end
      msc_pkg::OP_BT: begin
        mul_a = 33'(sq_r);
        mul_b = 33'(tension);
      end
      default: begin
        mul_a = 33'(vc);
        mul_b = $signed({16'd0, damp});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 66'(mul_a) * 66'(mul_b);
    case (cmd.op)
      msc_pkg::OP_PCAP: begin
        prev_r[0] <= qa_r;
        prev_r[1] <= qb_r;
      end
      msc_pkg::OP_CAP: begin
        vc_r <= vc;
        d_r  <= msc_pkg::sat32(66'(nxt) - 66'(own));
        dp_r <= msc_pkg::sat32(66'(prv) - 66'(own));
      end
      msc_pkg::OP_DMP: begin
        acc_r <= msc_pkg::sat32(66'(vc_r) - (prod_r >>> 16) + 66'(gadd));
      end
      msc_pkg::OP_SQ: begin
        sq_r <= msc_pkg::sat32(prod_r >>> 16);
      end
      msc_pkg::OP_BT: begin
        b_r <= msc_pkg::sat32(prod_r >>> 16);
      end
      msc_pkg::OP_AT: begin
        f_r <= msc_pkg::sat32(66'(msc_pkg::sat32(prod_r >>> 17)) + 66'(b_r));
        if (!cmd.second) begin
          d_r <= dp_r;
        end
      end
      msc_pkg::OP_ACC: begin
        acc_r <= msc_pkg::sat32(66'(acc_r) + 66'(f_r));
      end
      msc_pkg::OP_WB: begin
        nv_r[cmd.comp*32 +: 32] <= acc_r;
        np_r[cmd.comp*32 +: 32] <= msc_pkg::sat32(66'(own) + 66'(acc_r));
      end
      msc_pkg::OP_PWR: begin
        prev_r[cmd.side] <= qa_r;
      end
      msc_pkg::OP_EMIT: begin
        sec_r  <= cmd.sec;
        side_r <= cmd.side;
        last_r <= cmd.last;
        nx_r   <= np_r[31:0];
        ny_r   <= np_r[63:32];
        nz_r   <= np_r[95:64];
      end
      default: begin
      end
    endcase
  end

  assign out_section    = sec_r;
  assign out_side       = side_r;
  assign out_new_x      = nx_r;
  assign out_new_y      = ny_r;
  assign out_new_z      = nz_r;
  assign out_last_point = last_r;

endmodule

@@ test/tb_mass_spring_chain_step.sv @@
module tb_mass_spring_chain_step;
  timeunit 1ns;
  timeprecision 1ps;

  import msc_pkg::*;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  // one emitted point of a tick
  typedef struct {
    logic [4:0]         sec;
    logic               side;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } point_res_t;

  // one row of the directed part
  typedef struct {
    logic               cmd;
    logic [4:0]         sec;
    logic               side;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               typed;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_command = CMD_LOAD;
  logic [4:0]         in_section = '0;
  logic               in_side = 1'b0;
  logic signed [31:0] in_load_x = '0;
  logic signed [31:0] in_load_y = '0;
  logic signed [31:0] in_load_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [4:0]         out_section;
  logic               out_side;
  logic signed [31:0] out_new_x;
  logic signed [31:0] out_new_y;
  logic signed [31:0] out_new_z;
  logic               out_last_point;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  mass_spring_chain_step i_dut (.*);

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // predictor state: positions, velocities and register copies
  longint     pos_q[MAX_SECTIONS][2][3];
  longint     vel_q[MAX_SECTIONS][2][3];
  longint     old_pos[MAX_SECTIONS][2][3];
  bit         loaded_pt[MAX_SECTIONS][2];
  longint     tension_q = 0;
  longint     damping_q = 0;
  longint     gravity_q = 0;
  int         sections_q = 24;

  point_res_t pending_points[$];
  int         mismatches = 0;
  int         checked_points = 0;
  int         tick_cnt = 0;
  int         load_cnt = 0;
  int         hold_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // nonlinear pull of a neighbor on one component
  function automatic longint spring_pull(longint own, longint nb);
    longint d, ad, sq, a, b;
    d  = clamp32(nb - own);
    ad = (d < 0) ? -d : d;
    sq = clamp32((ad * d) >>> 16);
    a  = clamp32((sq * tension_q) >>> 17);
    b  = clamp32((d * tension_q) >>> 16);
    return clamp32(a + b);
  endfunction

  function automatic int active_sections();
    if (sections_q < 2) return 2;
    if (sections_q > MAX_SECTIONS) return MAX_SECTIONS;
    return sections_q;
  endfunction

  function automatic void place_point(logic [4:0] sec, logic side, longint x, longint y,
                                      longint z);
    if (sec >= MAX_SECTIONS) return;
    pos_q[sec][side][0] = x;
    pos_q[sec][side][1] = y;
    pos_q[sec][side][2] = z;
    for (int c = 0; c < 3; c++) vel_q[sec][side][c] = 0;
    loaded_pt[sec][side] = 1'b1;
  endfunction

  // one euler step of the chain, returns the number of emitted points
  function automatic int advance_chain(bit push_results);
    int         n, cnt;
    longint     damp, v;
    point_res_t r;
    n = active_sections();
    cnt = 0;
    damp = (damping_q > 65536) ? 65536 : damping_q;
    old_pos = pos_q;
    for (int s = 1; s + 1 < n; s++) begin
      for (int sd = 0; sd < 2; sd++) begin
        for (int c = 0; c < 3; c++) begin
          v = vel_q[s][sd][c];
          v = v - ((v * damp) >>> 16);
          if (c == 1) v = v + gravity_q;
          v = clamp32(v);
          v = clamp32(v + spring_pull(old_pos[s][sd][c], old_pos[s+1][sd][c]));
          v = clamp32(v + spring_pull(old_pos[s][sd][c], old_pos[s-1][sd][c]));
          vel_q[s][sd][c] = v;
        end
      end
    end
    for (int s = 1; s + 1 < n; s++) begin
      for (int sd = 0; sd < 2; sd++) begin
        for (int c = 0; c < 3; c++) pos_q[s][sd][c] = clamp32(pos_q[s][sd][c] + vel_q[s][sd][c]);
        r.sec  = 5'(s);
        r.side = sd[0];
        r.x    = pos_q[s][sd][0][31:0];
        r.y    = pos_q[s][sd][1][31:0];
        r.z    = pos_q[s][sd][2][31:0];
        r.last = (s + 2 == n) && (sd == 1);
        if (push_results) pending_points.push_back(r);
        cnt++;
      end
    end
    return cnt;
  endfunction

  // expected points that can be read straight off the loads (zero registers, 3 sections)
  point_res_t typed_points[4] = '{
    '{5'd1, 1'b0, 32'sh00010000, 32'shffff0000, 32'sh12345678, 1'b0},
    '{5'd1, 1'b1, 32'sh80000000, 32'sh7fffffff, 32'sh00000001, 1'b1},
    '{5'd1, 1'b0, 32'sh00010000, 32'shffff0000, 32'sh12345678, 1'b0},
    '{5'd1, 1'b1, 32'sh80000000, 32'sh7fffffff, 32'sh00000001, 1'b1}
  };
  int typed_idx = 0;

  // directed part: extremes, ignored loads, ticks with no motion
  dir_row_t dir_rows[13] = '{
    '{CMD_LOAD, 5'd0,  1'b0, 32'sh80000000, 32'sh7fffffff, 32'sh00000000, 1'b0},
    '{CMD_LOAD, 5'd0,  1'b1, 32'sh7fffffff, 32'sh80000000, 32'shffffffff, 1'b0},
    '{CMD_LOAD, 5'd1,  1'b0, 32'sh00010000, 32'shffff0000, 32'sh12345678, 1'b0},
    '{CMD_LOAD, 5'd1,  1'b1, 32'sh80000000, 32'sh7fffffff, 32'sh00000001, 1'b0},
    '{CMD_LOAD, 5'd2,  1'b0, 32'sh00000000, 32'sh00000000, 32'sh00000000, 1'b0},
    '{CMD_LOAD, 5'd2,  1'b1, 32'shffffffff, 32'shffffffff, 32'shffffffff, 1'b0},
    '{CMD_TICK, 5'd0,  1'b0, 32'sh0,        32'sh0,        32'sh0,        1'b1},
    // loads to sections past the point memory (24 and up) are dropped
    '{CMD_LOAD, 5'd31, 1'b0, 32'sh55555555, 32'sh55555555, 32'sh55555555, 1'b0},
    '{CMD_LOAD, 5'd24, 1'b1, 32'shaaaaaaaa, 32'shaaaaaaaa, 32'shaaaaaaaa, 1'b0},
    '{CMD_TICK, 5'd31, 1'b1, 32'shffffffff, 32'shffffffff, 32'shffffffff, 1'b1},
    '{CMD_LOAD, 5'd1,  1'b0, 32'sh00020000, 32'sh00030000, 32'shfffc0000, 1'b0},
    '{CMD_LOAD, 5'd23, 1'b1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0},
    '{CMD_TICK, 5'd0,  1'b0, 32'sh0,        32'sh0,        32'sh0,        1'b0}
  };

  // offer one item and wait for its transfer; called in the step of a rising edge
  task automatic push_item(logic cmd, logic [4:0] sec, logic side, logic signed [31:0] x,
                           logic signed [31:0] y, logic signed [31:0] z, bit typed);
    int n;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_section <= sec;
    in_side    <= side;
    in_load_x  <= x;
    in_load_y  <= y;
    in_load_z  <= z;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_LOAD) begin
      place_point(sec, side, x, y, z);
      if (sec < MAX_SECTIONS) load_cnt++;
    end else begin
      n = advance_chain(!typed);
      if (typed) begin
        for (int k = 0; k < n; k++) pending_points.push_back(typed_points[typed_idx++]);
      end
      tick_cnt++;
    end
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic signed [31:0] sv;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sv = val;
    case (idx)
      REG_TENSION:  tension_q  = sv;
      REG_DAMPING:  damping_q  = val[16:0];
      REG_GRAVITY:  gravity_q  = sv;
      REG_SECTIONS: sections_q = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_chain(logic [31:0] t, logic [31:0] d, logic [31:0] g, logic [31:0] s);
    write_reg(REG_TENSION, t);
    write_reg(REG_DAMPING, d);
    write_reg(REG_GRAVITY, g);
    write_reg(REG_SECTIONS, s);
  endtask

  // block is idle once nothing is pending and a load or an empty tick has drained
  task automatic drain();
    while (pending_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // a position near its rest spot along the chain, sometimes anywhere
  function automatic logic signed [31:0] near_rest(int sec, int comp);
    if ($urandom_range(0, 9) < 2) return $urandom;
    return 32'(sec * 131072 + comp * 40000 + $urandom_range(0, 8191) - 4096);
  endfunction

  // random items until cnt useful items have transferred
  task automatic random_items(int cnt, bit fast_ticks);
    int          n, got, fs, fd;
    bit          found;
    logic [4:0]  sec;
    logic        side;
    got = 0;
    while (got < cnt) begin
      n = active_sections();
      if ($urandom_range(0, 99) < (fast_ticks ? 40 : 15)) begin
        // a tick may only read loaded points, so fill holes first
        found = 1'b0;
        fs = 0;
        fd = 0;
        for (int s = 0; s < n; s++)
          for (int sd = 0; sd < 2; sd++)
            if (!found && !loaded_pt[s][sd]) begin
              found = 1'b1;
              fs = s;
              fd = sd;
            end
        if (found)
          push_item(CMD_LOAD, 5'(fs), fd[0], near_rest(fs, 0), near_rest(fs, 1),
                    near_rest(fs, 2), 1'b0);
        else
          push_item(CMD_TICK, 5'($urandom), 1'($urandom), $urandom, $urandom, $urandom, 1'b0);
        got++;
      end else begin
        sec  = ($urandom_range(0, 99) < 8) ? 5'($urandom_range(24, 31))
                                            : 5'($urandom_range(0, n - 1));
        side = 1'($urandom);
        push_item(CMD_LOAD, sec, side, near_rest(sec, 0), near_rest(sec, 1),
                  near_rest(sec, 2), 1'b0);
        if (sec < MAX_SECTIONS) got++;
      end
    end
    in_valid <= 1'b0;
  endtask

  // result side: check each transfer, then pick out_ready for the next edge
  always @(posedge clk) begin
    point_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point sec %0d side %0d", out_section, out_side);
      end else begin
        e = pending_points.pop_front();
        checked_points++;
        if (out_section !== e.sec || out_side !== e.side || out_new_x !== e.x ||
            out_new_y !== e.y || out_new_z !== e.z || out_last_point !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: exp sec %0d side %0d %h %h %h last %0d, got %0d %0d %h %h %h %0d",
                     e.sec, e.side, e.x, e.y, e.z, e.last, out_section, out_side,
                     out_new_x, out_new_y, out_new_z, out_last_point);
        end
      end
    end
    if (hold_cycles > 0) begin
      // long hold-off so the block backs up into its input
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on a three-section chain with zero registers
    write_reg(REG_SECTIONS, 32'd3);
    foreach (dir_rows[i])
      push_item(dir_rows[i].cmd, dir_rows[i].sec, dir_rows[i].side, dir_rows[i].x,
                dir_rows[i].y, dir_rows[i].z, dir_rows[i].typed);
    in_valid <= 1'b0;
    drain();

    // random phases, idle pattern rotates: none, sender, receiver, both
    for (int ph = 1; ph <= 8; ph++) begin
      case (ph)
        1: set_chain(32'h00010000, 32'h00001000, 32'hfffff000, 32'd5);
        2: set_chain(32'h7fffffff, 32'd65536, 32'h7fffffff, 32'd24);
        3: set_chain(32'h80000000, 32'h0001ffff, 32'h80000000, 32'd31);
        4: set_chain($urandom, $urandom_range(0, 65536), $urandom, 32'd1);
        5: set_chain($urandom_range(0, 32'h20000), 32'd0, $urandom, 32'd2);
        6: set_chain(32'h00008000, 32'd2000, 32'hffffff00, 32'd8);
        7: set_chain($urandom, $urandom, $urandom, 32'($urandom_range(0, 31)));
        default: set_chain($urandom_range(0, 32'h40000), $urandom_range(0, 65536),
                           $urandom_range(0, 4096), 32'($urandom_range(3, 7)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 85; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 85; end
        default: begin send_idle_pct = 33; recv_idle_pct = 33; end
      endcase
      if (ph == 6) hold_cycles = 3000;
      random_items(36, !(ph == 2 || ph == 3));
      drain();
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d loads and %0d ticks over 9 register settings", load_cnt, tick_cnt);
    $display("checked %0d points, %0d mismatches", checked_points, mismatches);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/msc_pkg.sv
hw/rtl/msc_ctrl.sv
hw/rtl/msc_dpath.sv
hw/rtl/mass_spring_chain_step.sv
test/tb_mass_spring_chain_step.sv
